// ===== rtl/core/interrupt_controller_regs_top_defines.svh =====
// assertion macros for the interrupt controller register block
// used by the port checker; no other dependencies
`ifndef INTERRUPT_CONTROLLER_REGS_TOP_DEFINES_SVH
`define INTERRUPT_CONTROLLER_REGS_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define INTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define INTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/intc_pkg.sv =====
// shared types and constants of the interrupt controller register block
// no dependencies
`timescale 1ns / 1ps

package intc_pkg;

  // bus operation codes
  localparam logic [1:0] OP_IDLE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // register byte offsets
  localparam logic [5:0] OFF_STATUS0 = 6'h00;
  localparam logic [5:0] OFF_STATUS1 = 6'h04;
  localparam logic [5:0] OFF_TYPE    = 6'h20;
  localparam logic [5:0] OFF_RAW     = 6'h30;
  localparam logic [5:0] OFF_ENABLE  = 6'h34;
  localparam logic [5:0] OFF_DISABLE = 6'h38;

  localparam logic [31:0] GLOBAL_MASK = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  address;
    logic [31:0] write_data;
    logic [30:0] source_levels;
  } intc_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        line0_request;
    logic        line1_request;
    logic [4:0]  pending_index;
    logic        index_valid;
  } intc_rsp_t;

  typedef struct packed {
    logic [31:0] enable_mask;
    logic [31:0] route_type;
  } intc_state_t;

endpackage

// ===== rtl/core/intc_regs.sv =====
// enable mask and route registers with their bus write decode
// depends on intc_pkg
`timescale 1ns / 1ps

module intc_regs #(
  parameter int NUM_SOURCES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  intc_pkg::intc_req_t req,
  input  logic                commit,
  output intc_pkg::intc_state_t state,
  output intc_pkg::intc_state_t state_next
);
  import intc_pkg::*;

  localparam logic [31:0] SRC_MASK = (32'h1 << (NUM_SOURCES - 1)) - 32'h1;
  localparam logic [31:0] KEEP_MASK = SRC_MASK | GLOBAL_MASK;

  intc_state_t regs;

  always_comb begin
    state_next = regs;
    if (req.operation == OP_WRITE) begin
      unique case (req.address)
        OFF_ENABLE: begin
          state_next.enable_mask = (regs.enable_mask | req.write_data) & KEEP_MASK;
        end
        OFF_DISABLE: begin
          state_next.enable_mask = regs.enable_mask & ~req.write_data & KEEP_MASK;
        end
        OFF_TYPE: begin
          state_next.route_type = req.write_data & SRC_MASK;
        end
        default: begin
          state_next = regs;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (commit) begin
      regs <= state_next;
    end
  end

  assign state = regs;

endmodule

// ===== rtl/core/intc_eval.sv =====
// status, read mux, request lines and pending-index encoder
// depends on intc_pkg
`timescale 1ns / 1ps

module intc_eval #(
  parameter int NUM_SOURCES = 32
) (
  input  intc_pkg::intc_req_t   req,
  input  intc_pkg::intc_state_t state,
  input  intc_pkg::intc_state_t state_next,
  input  logic                  line_select,
  output intc_pkg::intc_rsp_t   rsp
);
  import intc_pkg::*;

  localparam logic [31:0] SRC_MASK = (32'h1 << (NUM_SOURCES - 1)) - 32'h1;

  function automatic logic [31:0] status_of(input logic [31:0] raw,
                                            input logic [31:0] enable,
                                            input logic [31:0] route,
                                            input logic        line);
    logic [31:0] s;
    s = line ? (raw & enable & route) : (raw & enable & ~route);
    s[31] = (|s[30:0]) & enable[31];
    return s;
  endfunction

  logic [31:0] raw;
  logic [31:0] old_st0;
  logic [31:0] old_st1;
  logic [31:0] new_st0;
  logic [31:0] new_st1;
  logic [30:0] sel;
  logic [4:0]  idx;
  logic [31:0] rdata;

  assign raw     = {1'b0, req.source_levels} & SRC_MASK;
  assign old_st0 = status_of(raw, state.enable_mask, state.route_type, 1'b0);
  assign old_st1 = status_of(raw, state.enable_mask, state.route_type, 1'b1);
  assign new_st0 = status_of(raw, state_next.enable_mask, state_next.route_type, 1'b0);
  assign new_st1 = status_of(raw, state_next.enable_mask, state_next.route_type, 1'b1);
  assign sel     = line_select ? new_st1[30:0] : new_st0[30:0];

  // read data sees the registers before this access
  always_comb begin
    rdata = '0;
    if (req.operation == OP_READ) begin
      unique case (req.address)
        OFF_STATUS0: rdata = old_st0;
        OFF_STATUS1: rdata = old_st1;
        OFF_TYPE:    rdata = state.route_type;
        OFF_RAW:     rdata = raw;
        OFF_ENABLE:  rdata = state.enable_mask;
        default:     rdata = '0;
      endcase
    end
  end

  // highest set bit wins
  always_comb begin
    idx = '0;
    for (int b = 0; b < 31; b++) begin
      if (sel[b]) begin
        idx = 5'(b);
      end
    end
  end

  assign rsp.read_data     = rdata;
  assign rsp.line0_request = new_st0[31];
  assign rsp.line1_request = new_st1[31];
  assign rsp.pending_index = idx;
  assign rsp.index_valid   = |sel;

endmodule

// ===== rtl/core/interrupt_controller_regs_top.sv =====
// interrupt controller register block, top level
// requests take a single pass from input register to response register
// one request per cycle while the receiver does not stall the response
// reset: synchronous, clears both pipeline valid flags, the enable and route
// registers and the line select; payload registers are not reset
`timescale 1ns / 1ps

module interrupt_controller_regs_top #(
  parameter int NUM_SOURCES = 32
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_ready,
  input  intc_pkg::intc_req_t req,
  // response channel
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output intc_pkg::intc_rsp_t rsp,
  // line select register write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import intc_pkg::*;

  intc_req_t   req_r;
  logic        req_full;
  intc_rsp_t   rsp_r;
  logic        rsp_full;
  logic        line_select;
  logic        advance;
  intc_state_t state;
  intc_state_t state_next;
  intc_rsp_t   rsp_next;

  // request moves on when the response register is free or being drained
  assign advance   = req_full & (~rsp_full | rsp_ready);
  assign req_ready = ~req_full | advance;

  // line select writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_select <= 1'b0;
    end else if (cfg_valid) begin
      line_select <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_ready) begin
      req_full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_r <= req;
    end
  end

  // register state commits when its request moves to the response register
  intc_regs #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .req        (req_r),
    .commit     (advance),
    .state      (state),
    .state_next (state_next)
  );

  // read data from old state, request lines and index from new state
  intc_eval #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_eval (
    .req         (req_r),
    .state       (state),
    .state_next  (state_next),
    .line_select (line_select),
    .rsp         (rsp_next)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (advance) begin
      rsp_full <= 1'b1;
    end else if (rsp_ready) begin
      rsp_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp_next;
    end
  end

  assign rsp_valid = rsp_full;
  assign rsp       = rsp_r;

endmodule

// ===== rtl/core/intc_checker.sv =====
// port-level checks of the interrupt controller register block, with bind
// depends on intc_pkg and interrupt_controller_regs_top_defines.svh
`timescale 1ns / 1ps

`include "interrupt_controller_regs_top_defines.svh"

module intc_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input intc_pkg::intc_rsp_t rsp
);
  import intc_pkg::*;

  `INTC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `INTC_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp))
  `INTC_ASSERT_IMPL(a_idx_zero, clk, rst, rsp_valid && !rsp.index_valid, rsp.pending_index == 5'd0)
  `INTC_ASSERT_IMPL(a_idx_range, clk, rst, rsp_valid, rsp.pending_index != 5'd31)

endmodule

bind interrupt_controller_regs_top intc_checker u_intc_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== dv/tb_interrupt_controller_regs_top.sv =====
// self-checking testbench for the interrupt controller register block
// depends on intc_pkg and interrupt_controller_regs_top; a class predicts every response
`timescale 1ns / 1ps

module tb_interrupt_controller_regs_top;
  import intc_pkg::*;

  // operation code that the block treats like an idle sample
  localparam logic [1:0]  OP_SPARE = 2'd3;
  // unmapped offsets used by the directed requests
  localparam logic [5:0]  OFF_UNUSED = 6'h3C;
  localparam logic [5:0]  OFF_LAST   = 6'h3F;
  localparam logic [31:0] SRC_MASK = ~GLOBAL_MASK;

  // response predictor: keeps its own copy of the mask, route and line select
  class intc_response_predictor;
    logic [31:0] enable_mask;
    logic [31:0] route_type;
    logic        line_select;
    intc_rsp_t   expected_responses[$];
    int          requests_seen;
    int          responses_checked;
    int          errors;

    function new();
      enable_mask = '0;
      route_type = '0;
      line_select = 1'b0;
      requests_seen = 0;
      responses_checked = 0;
      errors = 0;
    endfunction

    function void set_line_select(logic value);
      line_select = value;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    // status word of one line, bit 31 only with global enable on
    function logic [31:0] line_status(logic [30:0] raw, logic line);
      logic [31:0] enabled;
      logic [31:0] status;
      enabled = {1'b0, raw} & enable_mask & SRC_MASK;
      status = line ? (enabled & route_type) : (enabled & ~route_type);
      if (status != '0 && enable_mask[31]) status[31] = 1'b1;
      return status;
    endfunction

    function void note_request(intc_req_t r);
      intc_rsp_t   e;
      logic [31:0] sel;
      logic [31:0] st0;
      logic [31:0] st1;
      e = '0;
      requests_seen++;
      // read data comes from the state before any write of this request
      if (r.operation == OP_READ) begin
        case (r.address)
          OFF_STATUS0: e.read_data = line_status(r.source_levels, 1'b0);
          OFF_STATUS1: e.read_data = line_status(r.source_levels, 1'b1);
          OFF_TYPE:    e.read_data = route_type;
          OFF_RAW:     e.read_data = {1'b0, r.source_levels};
          OFF_ENABLE:  e.read_data = enable_mask;
          default:     e.read_data = '0;
        endcase
      end else if (r.operation == OP_WRITE) begin
        case (r.address)
          OFF_ENABLE:  enable_mask = enable_mask | r.write_data;
          OFF_DISABLE: enable_mask = enable_mask & ~r.write_data;
          OFF_TYPE:    route_type = r.write_data & SRC_MASK;
          default: ;
        endcase
      end
      st0 = line_status(r.source_levels, 1'b0);
      st1 = line_status(r.source_levels, 1'b1);
      e.line0_request = st0[31];
      e.line1_request = st1[31];
      sel = (line_select ? st1 : st0) & SRC_MASK;
      for (int b = 30; b >= 0; b--) begin
        if (sel[b]) begin
          e.pending_index = b[4:0];
          e.index_valid = 1'b1;
          break;
        end
      end
      expected_responses.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (exp_val !== got_val) begin
        $error("%s mismatch: expected %h, actual %h", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_response(intc_rsp_t got);
      intc_rsp_t e;
      if (expected_responses.size() == 0) begin
        $error("response with no request outstanding: %h", got);
        errors++;
        return;
      end
      e = expected_responses.pop_front();
      responses_checked++;
      compare_field("read_data", e.read_data, got.read_data);
      compare_field("line0_request", 32'(e.line0_request), 32'(got.line0_request));
      compare_field("line1_request", 32'(e.line1_request), 32'(got.line1_request));
      compare_field("pending_index", 32'(e.pending_index), 32'(got.pending_index));
      compare_field("index_valid", 32'(e.index_valid), 32'(got.index_valid));
    endfunction
  endclass

  // clock, reset and block ports, all known from time zero
  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  intc_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  intc_rsp_t rsp;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  // idling knobs per phase; burst_mode switches both sides to full rate for a while
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          burst_mode = 1'b0;

  intc_response_predictor sb;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  interrupt_controller_regs_top #(
    .NUM_SOURCES(32)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // receiver: stalls at random, never while in a burst
  always @(posedge clk) begin
    rsp_ready <= burst_mode || ($urandom_range(99) >= recv_stall_pct);
  end

  // response monitor: values seen here are the ones from before this edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // drive one request, with optional idle cycles in front, and wait for acceptance
  task automatic send_request(input intc_req_t item);
    while (!burst_mode && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!(req_valid && req_ready));
    sb.note_request(item);
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [5:0] addr,
                             input logic [31:0] wdata, input logic [30:0] levels);
    intc_req_t item;
    item.operation = op;
    item.address = addr;
    item.write_data = wdata;
    item.source_levels = levels;
    send_request(item);
  endtask

  // stop sending and let every outstanding response come back
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // one response per request, so the repeat below covers the pipeline
    repeat (3) @(posedge clk);
  endtask

  // line select write, only ever issued with the block idle
  task automatic write_line_select(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.set_line_select(value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly real register traffic with random content, plus some noise
  task automatic run_random_phase(input int count);
    intc_req_t item;
    int unsigned kind;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) burst_mode = ($urandom_range(3) == 0);
      kind = $urandom_range(99);
      case ($urandom_range(3))
        0: item.source_levels = 31'($urandom);
        1: item.source_levels = 31'h1 << $urandom_range(30);
        2: item.source_levels = '1;
        default: item.source_levels = 31'($urandom & $urandom);
      endcase
      case ($urandom_range(3))
        0: item.write_data = $urandom;
        1: item.write_data = 32'h1 << $urandom_range(31);
        2: item.write_data = '1;
        default: item.write_data = $urandom & $urandom;
      endcase
      item.address = 6'($urandom_range(63));
      if (kind < 40) begin
        item.operation = OP_WRITE;
        case ($urandom_range(3))
          0, 1: begin
            item.address = OFF_ENABLE;
            if ($urandom_range(1)) item.write_data |= GLOBAL_MASK;
          end
          2: begin
            // disables stay mostly sparse so the mask does not sit at zero
            item.address = OFF_DISABLE;
            if ($urandom_range(1)) item.write_data = 32'h1 << $urandom_range(31);
          end
          default: item.address = OFF_TYPE;
        endcase
      end else if (kind < 80) begin
        item.operation = OP_READ;
        case ($urandom_range(5))
          0: item.address = OFF_STATUS0;
          1: item.address = OFF_STATUS1;
          2: item.address = OFF_TYPE;
          3: item.address = OFF_RAW;
          4: item.address = OFF_ENABLE;
          default: item.address = OFF_DISABLE;
        endcase
      end else if (kind < 88) begin
        item.operation = OP_IDLE;
      end else if (kind < 92) begin
        item.operation = OP_SPARE;
      end else begin
        item.operation = 2'($urandom_range(3));
      end
      send_request(item);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values, global on and off, routing, unmapped offsets
    write_line_select(1'b0);
    send_fields(OP_READ,  OFF_ENABLE,  32'h0,         '1);
    send_fields(OP_READ,  OFF_TYPE,    32'h0,         '1);
    send_fields(OP_READ,  OFF_STATUS0, 32'h0,         '1);
    send_fields(OP_IDLE,  OFF_STATUS0, 32'h0,         '1);
    // sources enabled but global off: index reports, request lines stay low
    send_fields(OP_WRITE, OFF_ENABLE,  32'h7FFF_FFFF, '1);
    send_fields(OP_READ,  OFF_STATUS0, 32'h0,         '1);
    send_fields(OP_WRITE, OFF_ENABLE,  GLOBAL_MASK,   '1);
    send_fields(OP_READ,  OFF_STATUS0, 32'h0,         '1);
    // route bit 31 does not exist
    send_fields(OP_WRITE, OFF_TYPE,    32'hFFFF_FFFF, 31'h5555_5555);
    send_fields(OP_READ,  OFF_TYPE,    32'h0,         31'h5555_5555);
    send_fields(OP_READ,  OFF_STATUS1, 32'h0,         31'h5555_5555);
    send_fields(OP_READ,  OFF_STATUS0, 32'h0,         31'h5555_5555);
    send_fields(OP_WRITE, OFF_TYPE,    32'h0000_FFFF, 31'h2AAA_AAAA);
    send_fields(OP_READ,  OFF_RAW,     32'h0,         31'h2AAA_AAAA);
    // the spare operation code behaves as an idle sample
    send_fields(OP_SPARE, OFF_ENABLE,  32'h0,         '1);
    send_fields(OP_WRITE, OFF_UNUSED,  32'hFFFF_FFFF, '1);
    send_fields(OP_READ,  OFF_LAST,    32'h0,         '1);
    send_fields(OP_READ,  OFF_DISABLE, 32'h0,         '1);
    send_fields(OP_WRITE, OFF_DISABLE, GLOBAL_MASK,   '1);
    send_fields(OP_READ,  OFF_STATUS1, 32'h0,         '1);
    send_fields(OP_WRITE, OFF_DISABLE, 32'hFFFF_FFFF, '1);
    send_fields(OP_READ,  OFF_ENABLE,  32'h0,         '1);
    // lowest source alone
    send_fields(OP_WRITE, OFF_ENABLE,  32'h8000_0001, 31'h1);
    send_fields(OP_IDLE,  OFF_STATUS0, 32'h0,         31'h0);
    send_fields(OP_WRITE, OFF_ENABLE,  32'hFFFF_FFFF, 31'h4000_0000);
    drain();

    // full rate both sides
    write_line_select(1'b1);
    run_random_phase(475);
    drain();

    // sender gaps, with one full pause in the middle
    write_line_select(1'b0);
    send_idle_pct = 49;
    run_random_phase(240);
    drain();
    run_random_phase(235);
    drain();

    // receiver stalls
    send_idle_pct = 0;
    recv_stall_pct = 49;
    write_line_select(1'b1);
    run_random_phase(475);
    drain();

    // both sides idle now and then
    send_idle_pct = 19;
    recv_stall_pct = 19;
    write_line_select(1'b0);
    run_random_phase(475);
    drain();

    sb.errors += sb.pending();
    $display("covered %0d requests, %0d responses checked, line select 0 and 1",
             sb.requests_seen, sb.responses_checked);
    $display("phases: full rate, sender gaps with a pause, receiver stalls, both");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
